### sv/plpbs_pkg.sv
// Shared types and constants for the pixel layer priority and blend select block.
package plpbs_pkg;

    localparam int unsigned NUM_LAYERS = 6;
    localparam int unsigned COLOR_W    = 16;
    localparam int unsigned KEY_W      = 5;

    localparam logic [COLOR_W-1:0] TRANSPARENT_CODE = 16'h8000;

    localparam logic [2:0] LAYER_SPRITE   = 3'd4;
    localparam logic [2:0] LAYER_BACKDROP = 3'd5;

    // backdrop sorts after every real layer
    localparam logic [KEY_W-1:0] BACKDROP_KEY = 5'h1F;

    typedef enum logic [2:0] {
        CFG_LAYER_ENABLE  = 3'd0,
        CFG_BG_PRIORITIES = 3'd1,
        CFG_FIRST_MASK    = 3'd2,
        CFG_SECOND_MASK   = 3'd3,
        CFG_BACKDROP      = 3'd4
    } cfg_index_t;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [KEY_W-1:0]   key_t;

endpackage

### sv/pixel_layer_priority_blend_select_top.sv
// Top level: layer priority ordering and blend target selection for one pixel.
//
// One pixel request per clock in and one result per clock out while the output
// is not stalled. A request is captured in an input register, sorted and
// selected by a single level of compare-and-mux logic, and held in a result
// register. The result is on the outputs once the result register loads it,
// and can be taken when the output is not stalled.
// The input register and the result register together let a new request be
// taken while a finished result still waits on out_ready. Layer order is
// priority 0..3, sprite ahead of BG0..BG3 within a priority, backdrop last.
// Configuration writes take effect at once and are meant for idle periods.
module pixel_layer_priority_blend_select_top
    import plpbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] bg0_color,
    input  logic [15:0] bg1_color,
    input  logic [15:0] bg2_color,
    input  logic [15:0] bg3_color,
    input  logic [15:0] sprite_color,
    input  logic [1:0]  sprite_priority,
    input  logic        sprite_semi,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] top_color,
    output logic [2:0]  top_layer,
    output logic        single_valid,
    output logic [15:0] single_color,
    output logic        pair_valid,
    output logic [15:0] pair_first_color,
    output logic [15:0] pair_second_color
);

    // configuration
    logic [4:0]  layer_enable_reg;
    logic [7:0]  bg_priorities_reg;
    logic [5:0]  first_mask_reg;
    logic [5:0]  second_mask_reg;
    logic [14:0] backdrop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_enable_reg  <= '0;
            bg_priorities_reg <= '0;
            first_mask_reg    <= '0;
            second_mask_reg   <= '0;
            backdrop_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LAYER_ENABLE:  layer_enable_reg  <= cfg_data[4:0];
                CFG_BG_PRIORITIES: bg_priorities_reg <= cfg_data[7:0];
                CFG_FIRST_MASK:    first_mask_reg    <= cfg_data[5:0];
                CFG_SECOND_MASK:   second_mask_reg   <= cfg_data[5:0];
                CFG_BACKDROP:      backdrop_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_accept;
    logic s2_load;

    assign s2_load   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s2_load;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    color_t     s1_bg_color_reg [4];
    color_t     s1_spr_color_reg;
    logic [1:0] s1_spr_pri_reg;
    logic       s1_semi_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_bg_color_reg[0] <= bg0_color;
            s1_bg_color_reg[1] <= bg1_color;
            s1_bg_color_reg[2] <= bg2_color;
            s1_bg_color_reg[3] <= bg3_color;
            s1_spr_color_reg   <= sprite_color;
            s1_spr_pri_reg     <= sprite_priority;
            s1_semi_reg        <= sprite_semi;
        end
    end

    // entry i is layer i: BG0-BG3, sprite, backdrop
    color_t                  ent_color [NUM_LAYERS];
    key_t                    ent_key   [NUM_LAYERS];
    logic [NUM_LAYERS-1:0]   ent_on;
    logic [NUM_LAYERS-1:0]   is_first;
    logic [NUM_LAYERS-1:0]   is_second;
    logic [NUM_LAYERS-1:0]   mask_a;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ent_color[i] = s1_bg_color_reg[i];
            ent_key[i]   = {bg_priorities_reg[2*i +: 2], 3'(i + 1)};
            ent_on[i]    = layer_enable_reg[i] && (s1_bg_color_reg[i] != TRANSPARENT_CODE);
        end
        ent_color[LAYER_SPRITE] = s1_spr_color_reg;
        ent_key[LAYER_SPRITE]   = {s1_spr_pri_reg, 3'd0};
        ent_on[LAYER_SPRITE]    = layer_enable_reg[4] && (s1_spr_color_reg != TRANSPARENT_CODE);
        ent_color[LAYER_BACKDROP] = {1'b0, backdrop_reg};
        ent_key[LAYER_BACKDROP]   = BACKDROP_KEY;
        ent_on[LAYER_BACKDROP]    = 1'b1;
    end

    // rank = number of visible entries sorted ahead; keys are unique
    always_comb
    begin
        logic [NUM_LAYERS-1:0] ahead;
        for (int i = 0; i < NUM_LAYERS; i++)
        begin
            for (int j = 0; j < NUM_LAYERS; j++)
                ahead[j] = ent_on[j] && (ent_key[j] < ent_key[i]);
            is_first[i]  = ent_on[i] && (ahead == '0);
            is_second[i] = ent_on[i] && $onehot(ahead);
        end
    end

    assign mask_a = s1_semi_reg ? (NUM_LAYERS'(1) << LAYER_SPRITE) : first_mask_reg;

    color_t     first_color;
    color_t     second_color;
    logic [2:0] first_layer;
    logic       second_found;
    logic       first_in_a;
    logic       second_in_b;
    logic       single_found;
    color_t     single_sel;
    logic       pair_found;

    always_comb
    begin
        first_color  = '0;
        second_color = '0;
        first_layer  = '0;
        for (int i = 0; i < NUM_LAYERS; i++)
        begin
            if (is_first[i])
            begin
                first_color = ent_color[i];
                first_layer = 3'(i);
            end
            if (is_second[i])
                second_color = ent_color[i];
        end
        second_found = |is_second;
        first_in_a   = |(is_first & mask_a);
        second_in_b  = |(is_second & second_mask_reg);

        if (s1_semi_reg)
        begin
            single_found = ent_on[LAYER_SPRITE];
            single_sel   = ent_color[LAYER_SPRITE];
        end
        else
        begin
            single_found = |(is_first & first_mask_reg);
            single_sel   = first_color;
        end
        pair_found = second_found && first_in_a && second_in_b;
    end

    // result register
    color_t     top_color_reg;
    logic [2:0] top_layer_reg;
    logic       single_valid_reg;
    color_t     single_color_reg;
    logic       pair_valid_reg;
    color_t     pair_first_reg;
    color_t     pair_second_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            top_color_reg    <= first_color;
            top_layer_reg    <= first_layer;
            single_valid_reg <= single_found;
            single_color_reg <= single_found ? single_sel : '0;
            pair_valid_reg   <= pair_found;
            pair_first_reg   <= pair_found ? first_color : '0;
            pair_second_reg  <= pair_found ? second_color : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign top_color         = top_color_reg;
    assign top_layer         = top_layer_reg;
    assign single_valid      = single_valid_reg;
    assign single_color      = single_color_reg;
    assign pair_valid        = pair_valid_reg;
    assign pair_first_color  = pair_first_reg;
    assign pair_second_color = pair_second_reg;

    // a pair always implies a single-target source
    a_pair_implies_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pair_valid_reg |-> single_valid_reg)
        else $error("pair without single-target source");

    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !single_valid_reg |-> single_color_reg == '0)
        else $error("single_color not cleared");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("request stalled without a full pipeline");

    a_exactly_one_top: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot(is_first))
        else $error("top entry not unique");

endmodule
